@@ src/mprd_pkg.sv @@
`timescale 1ns / 1ps

package mprd_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_GLITCH_MIN = 2'd0;
	localparam logic [1:0] REG_DOT_MAX    = 2'd1;
	localparam logic [1:0] REG_GAP        = 2'd2;

	// Register reset values
	localparam logic [15:0] GLITCH_MIN_RST = 16'd30;
	localparam logic [15:0] DOT_MAX_RST    = 16'd450;
	localparam logic [15:0] GAP_RST        = 16'd900;

	localparam int          NUM_SYMS      = 36;
	localparam logic [6:0]  CHAR_UNKNOWN  = 7'h3F;

	typedef logic [2:0] sym_len_t;
	typedef logic [4:0] sym_bits_t;
	typedef logic [6:0] sym_char_t;

	// Symbol table: length, elements (1 dash, first element most significant), character
	localparam sym_len_t SYM_LEN [NUM_SYMS] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
		3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
		3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
	};

	localparam sym_bits_t SYM_BITS [NUM_SYMS] = '{
		5'h01, 5'h08, 5'h0A, 5'h04, 5'h00, 5'h02, 5'h06, 5'h00, 5'h00, 5'h07, 5'h05, 5'h04,
		5'h03, 5'h02, 5'h07, 5'h06, 5'h0D, 5'h02, 5'h00, 5'h01, 5'h01, 5'h01, 5'h03, 5'h09,
		5'h0B, 5'h0C,
		5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E, 5'h1F
	};

	localparam sym_char_t SYM_CHAR [NUM_SYMS] = '{
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C,
		7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
		7'h59, 7'h5A,
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
	};

endpackage

@@ src/morse_pulse_receiver_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// -------   ---------------------   ------------------------------------------------
// input     in_valid / in_ready     line_level
// output    out_valid / out_ready   ascii_char, recognized, element_count, element_pattern
// config    cfg_we (no wait)        cfg_index, cfg_data
//
// One tick is taken per cycle while in_ready is high; the pulse/gap counters, element
// shift register and the 36-entry symbol compare all sit between the state registers and
// the result register, so a result appears the cycle after the tick ending a character.
// Reset (arst_n low) clears all but the result data and restores the register defaults.
// A result held in the output register blocks new ticks only while out_ready is low.
module morse_pulse_receiver_decoder #(
	parameter int MAX_ELEMENTS = 6,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        line_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  ascii_char,
	output logic        recognized,
	output logic [2:0]  element_count,
	output logic [5:0]  element_pattern,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mprd_pkg::*;

	localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam int PAT_W = (MAX_ELEMENTS > 6) ? MAX_ELEMENTS : 6;

	logic [15:0]             glitch_min_q, dot_max_q, gap_ms_q;
	logic                    active_q, active_n;
	logic [COUNT_WIDTH-1:0]  pulse_q, pulse_n, gap_q, gap_n;
	logic [MAX_ELEMENTS-1:0] pat_q, pat_n;
	logic [LEN_W-1:0]        len_q, len_n;
	logic                    ovf_q, ovf_n;
	logic                    dash, fire, accept;

	logic [NUM_SYMS-1:0]     sym_hit;
	logic [6:0]              sym_char;
	logic [6:0]              res_char;
	logic                    res_recog;
	logic [PAT_W-1:0]        pat_ext;

	logic                    out_valid_q;
	logic [6:0]              ascii_char_q;
	logic                    recognized_q;
	logic [2:0]              element_count_q;
	logic [5:0]              element_pattern_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_min_q <= GLITCH_MIN_RST;
			dot_max_q    <= DOT_MAX_RST;
			gap_ms_q     <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLITCH_MIN: glitch_min_q <= cfg_data;
				REG_DOT_MAX:    dot_max_q    <= cfg_data;
				REG_GAP:        gap_ms_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the pulse/gap counters and collect elements
	always_comb begin
		active_n = active_q;
		pulse_n  = pulse_q;
		gap_n    = gap_q;
		pat_n    = pat_q;
		len_n    = len_q;
		ovf_n    = ovf_q;
		dash     = 1'b0;
		if (active_q) begin
			pulse_n = (pulse_q == '1) ? pulse_q : pulse_q + COUNT_WIDTH'(1);
			dash    = !(CMP_W'(pulse_n) < CMP_W'(dot_max_q));
			if (!line_level) begin
				active_n = 1'b0;
				gap_n    = '0;
				if (CMP_W'(pulse_n) > CMP_W'(glitch_min_q)) begin
					if (len_q >= LEN_W'(MAX_ELEMENTS)) begin
						ovf_n = 1'b1;
					end else begin
						pat_n = {pat_q[MAX_ELEMENTS-2:0], dash};
						len_n = len_q + LEN_W'(1);
					end
				end
			end
		end else if (line_level) begin
			active_n = 1'b1;
			pulse_n  = '0;
		end else begin
			gap_n = (gap_q == '1) ? gap_q : gap_q + COUNT_WIDTH'(1);
		end
		fire = !active_n && (len_n != '0) && (CMP_W'(gap_n) > CMP_W'(gap_ms_q));
	end

	// Match the collected code against the symbol table
	always_comb begin
		sym_char = '0;
		for (int i = 0; i < NUM_SYMS; i++) begin
			sym_hit[i] = (LEN_W'(SYM_LEN[i]) == len_n) &&
				(PAT_W'(SYM_BITS[i]) == PAT_W'(pat_n));
			if (sym_hit[i]) begin
				sym_char = sym_char | SYM_CHAR[i];
			end
		end
		res_recog = !ovf_n && (|sym_hit);
		res_char  = res_recog ? sym_char : CHAR_UNKNOWN;
		pat_ext   = PAT_W'(pat_n);
	end

	// Update receiver state on each accepted tick; clear the code once decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pulse_q  <= '0;
			gap_q    <= '0;
			pat_q    <= '0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			active_q <= active_n;
			pulse_q  <= pulse_n;
			gap_q    <= gap_n;
			if (fire) begin
				pat_q <= '0;
				len_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pat_q <= pat_n;
				len_q <= len_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fire) begin
			ascii_char_q      <= res_char;
			recognized_q      <= res_recog;
			element_count_q   <= len_n[2:0];
			element_pattern_q <= pat_ext[5:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign ascii_char      = ascii_char_q;
	assign recognized      = recognized_q;
	assign element_count   = element_count_q;
	assign element_pattern = element_pattern_q;

endmodule

@@ verif/tb_morse_pulse_receiver_decoder.sv @@
`timescale 1ns / 1ps

module tb_morse_pulse_receiver_decoder;
	import mprd_pkg::*;

	localparam int MAX_ELEMS = 6;

	typedef struct packed {
		logic [6:0] ascii;
		logic       hit;
		logic [2:0] count;
		logic [5:0] pattern;
	} morse_char_t;

	typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        line_level = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  ascii_char;
	logic        recognized;
	logic [2:0]  element_count;
	logic [5:0]  element_pattern;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_GLITCH_MIN;
	logic [15:0] cfg_data = 16'd0;

	// decoder model: timing limits and receive state
	logic [15:0] glitch_lim = GLITCH_MIN_RST;
	logic [15:0] dot_lim = DOT_MAX_RST;
	logic [15:0] gap_lim = GAP_RST;
	logic        line_hi = 1'b0;
	logic [15:0] pulse_cnt = 16'd0;
	logic [15:0] low_cnt = 16'd0;
	logic [5:0]  elem_bits = 6'd0;
	logic [2:0]  elem_len = 3'd0;
	logic        elem_ovf = 1'b0;

	logic        level_q[$];
	morse_char_t chars_due[$];
	int          ticks_queued = 0;
	int          errors = 0;
	logic        tick_taken = 1'b0;
	int          burst_left = 0;
	int          idle_left = 0;
	ready_mode_t ready_mode = RDY_ALWAYS;
	int          ready_left = 0;
	int          ready_phase = 0;

	morse_pulse_receiver_decoder i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.line_level      (line_level),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ascii_char      (ascii_char),
		.recognized      (recognized),
		.element_count   (element_count),
		.element_pattern (element_pattern),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the decoder model by one tick; queue a character when the gap closes it
	task automatic decode_tick(input logic level);
		logic [7:0]  sym;
		logic        hit;
		morse_char_t due;
		if (line_hi) begin
			if (pulse_cnt != 16'hFFFF)
				pulse_cnt++;
			if (!level) begin
				line_hi = 1'b0;
				low_cnt = 16'd0;
				if (pulse_cnt > glitch_lim) begin
					if (elem_len >= MAX_ELEMS) begin
						elem_ovf = 1'b1;
					end else begin
						elem_bits = {elem_bits[4:0], pulse_cnt >= dot_lim};
						elem_len++;
					end
				end
			end
		end else if (level) begin
			line_hi = 1'b1;
			pulse_cnt = 16'd0;
		end else if (low_cnt != 16'hFFFF) begin
			low_cnt++;
		end

		if (!line_hi && elem_len != 0 && low_cnt > gap_lim) begin
			hit = 1'b1;
			if (elem_ovf) begin
				sym = {1'b0, CHAR_UNKNOWN};
				hit = 1'b0;
			end else begin
				case ({elem_len, elem_bits})
					{3'd2, 6'b000001}: sym = "A";
					{3'd4, 6'b001000}: sym = "B";
					{3'd4, 6'b001010}: sym = "C";
					{3'd3, 6'b000100}: sym = "D";
					{3'd1, 6'b000000}: sym = "E";
					{3'd4, 6'b000010}: sym = "F";
					{3'd3, 6'b000110}: sym = "G";
					{3'd4, 6'b000000}: sym = "H";
					{3'd2, 6'b000000}: sym = "I";
					{3'd4, 6'b000111}: sym = "J";
					{3'd3, 6'b000101}: sym = "K";
					{3'd4, 6'b000100}: sym = "L";
					{3'd2, 6'b000011}: sym = "M";
					{3'd2, 6'b000010}: sym = "N";
					{3'd3, 6'b000111}: sym = "O";
					{3'd4, 6'b000110}: sym = "P";
					{3'd4, 6'b001101}: sym = "Q";
					{3'd3, 6'b000010}: sym = "R";
					{3'd3, 6'b000000}: sym = "S";
					{3'd1, 6'b000001}: sym = "T";
					{3'd3, 6'b000001}: sym = "U";
					{3'd4, 6'b000001}: sym = "V";
					{3'd3, 6'b000011}: sym = "W";
					{3'd4, 6'b001001}: sym = "X";
					{3'd4, 6'b001011}: sym = "Y";
					{3'd4, 6'b001100}: sym = "Z";
					{3'd5, 6'b001111}: sym = "1";
					{3'd5, 6'b000111}: sym = "2";
					{3'd5, 6'b000011}: sym = "3";
					{3'd5, 6'b000001}: sym = "4";
					{3'd5, 6'b000000}: sym = "5";
					{3'd5, 6'b010000}: sym = "6";
					{3'd5, 6'b011000}: sym = "7";
					{3'd5, 6'b011100}: sym = "8";
					{3'd5, 6'b011110}: sym = "9";
					{3'd5, 6'b011111}: sym = "0";
					default: begin
						sym = {1'b0, CHAR_UNKNOWN};
						hit = 1'b0;
					end
				endcase
			end
			due.ascii = sym[6:0];
			due.hit = hit;
			due.count = elem_len;
			due.pattern = elem_bits;
			chars_due.push_back(due);
			elem_bits = 6'd0;
			elem_len = 3'd0;
			elem_ovf = 1'b0;
		end
	endtask

	// Sample both channels on the rising edge
	always @(posedge clk) begin : monitor
		morse_char_t want;
		if (!arst_n) begin
			tick_taken = 1'b0;
		end else begin
			tick_taken = in_valid && in_ready === 1'b1;
			if (tick_taken)
				decode_tick(line_level);
			if (out_valid === 1'b1 && out_ready) begin
				if (chars_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected character: expected none, got %h %b %0d %b",
						$time, ascii_char, recognized, element_count, element_pattern);
				end else begin
					want = chars_due.pop_front();
					if (ascii_char !== want.ascii || recognized !== want.hit ||
							element_count !== want.count || element_pattern !== want.pattern) begin
						errors++;
						$display("%0t: mismatch: expected %h %b %0d %b, got %h %b %0d %b",
							$time, want.ascii, want.hit, want.count, want.pattern,
							ascii_char, recognized, element_count, element_pattern);
					end
				end
			end
		end
	end

	// Feed ticks in bursts; hold the transaction until it is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || tick_taken)) begin
			if (idle_left != 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (level_q.size() != 0) begin
				in_valid <= 1'b1;
				line_level <= level_q.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					idle_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result channel in stretches of changing pattern
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			ready_left = $urandom_range(1, 64);
		end
		ready_left--;
		ready_phase++;
		case (ready_mode)
			RDY_ALWAYS: out_ready <= 1'b1;
			RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default:    out_ready <= (ready_phase % 3 == 0);
		endcase
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GLITCH_MIN: glitch_lim = val;
			REG_DOT_MAX:    dot_lim = val;
			REG_GAP:        gap_lim = val;
			default:        ;
		endcase
	endtask

	task automatic set_timing(input int glitch, input int dot, input int gap);
		write_reg(REG_GLITCH_MIN, 16'(glitch));
		write_reg(REG_DOT_MAX, 16'(dot));
		write_reg(REG_GAP, 16'(gap));
	endtask

	// Hold until the feed is empty and every character has come out
	task automatic wait_idle();
		while (level_q.size() != 0 || in_valid || chars_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_run(input logic level, input int count);
		for (int k = 0; k < count; k++)
			level_q.push_back(level);
		ticks_queued += count;
	endtask

	// High run that lands in the dot or dash window of the current limits
	task automatic push_element(input logic dash);
		int lo;
		int n;
		lo = glitch_lim + 1;
		if (!dash && dot_lim > lo)
			n = $urandom_range(lo, dot_lim - 1);
		else
			n = ((dot_lim > lo) ? int'(dot_lim) : lo) + $urandom_range(0, 2);
		push_run(1'b1, n);
	endtask

	task automatic push_code(input int len, input logic [7:0] bits);
		for (int i = len - 1; i >= 0; i--) begin
			push_element(bits[i]);
			if (i != 0)
				push_run(1'b0, $urandom_range(1, gap_lim + 1));
		end
		push_run(1'b0, gap_lim + 2);
	endtask

	// Well-formed character with random content, glitches mixed in
	task automatic push_random_char();
		int n_elem;
		n_elem = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(6, 8);
		for (int e = 0; e < n_elem; e++) begin
			if (glitch_lim != 0 && $urandom_range(0, 5) == 0) begin
				push_run(1'b1, $urandom_range(1, glitch_lim));
				push_run(1'b0, $urandom_range(1, gap_lim + 1));
			end
			push_element(1'($urandom_range(0, 1)));
			if (e != n_elem - 1)
				push_run(1'b0, $urandom_range(1, gap_lim + 1));
		end
		push_run(1'b0, gap_lim + 2 + $urandom_range(0, 4));
	endtask

	initial begin
		int g;
		int d;
		int mark;
		int made;
		int pick;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limits: low before any element, glitch at the limit, dot just over it,
		// dash at the dot limit; a lower gap then releases the held code
		push_run(1'b0, 10);
		push_run(1'b1, 30);
		push_run(1'b0, 5);
		push_run(1'b1, 31);
		push_run(1'b0, 3);
		push_run(1'b1, 450);
		push_run(1'b0, 10);
		wait_idle();
		write_reg(REG_GAP, 16'd1);
		push_run(1'b0, 1);

		// Every code of up to five elements, then six, seven and eight elements (the last two overflow)
		wait_idle();
		set_timing(0, 2, 1);
		for (int len = 1; len <= 5; len++)
			for (int c = 0; c < (1 << len); c++)
				push_code(len, 8'(c));
		push_code(6, 8'($urandom_range(0, 63)));
		push_code(7, 8'($urandom_range(0, 127)));
		push_code(8, 8'hFF);

		// Zero gap: decode lands one tick after the falling edge
		wait_idle();
		write_reg(REG_GAP, 16'd0);
		push_code(1, 8'd0);
		push_code(2, 8'd1);
		push_code(7, 8'h55);

		// Pulse length boundaries around glitch and dot limits
		wait_idle();
		set_timing(3, 6, 4);
		push_run(1'b1, 3);
		push_run(1'b0, 5);
		push_run(1'b1, 4);
		push_run(1'b0, 5);
		push_run(1'b1, 5);
		push_run(1'b0, 5);
		push_run(1'b1, 6);
		push_run(1'b0, 6);

		// Largest glitch limit swallows pulses; a dot limit of 1 makes dashes only
		wait_idle();
		set_timing(16'hFFFF, 1, 1);
		push_run(1'b1, 5);
		push_run(1'b0, 10);
		wait_idle();
		write_reg(REG_GLITCH_MIN, 16'd0);
		push_run(1'b1, 1);
		push_run(1'b0, 3);
		push_code(3, 8'd0);

		// Random phases with small limits so characters come often
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();
			g = $urandom_range(0, 4);
			d = (ph == 2) ? $urandom_range(1, g + 1) : g + $urandom_range(2, 8);
			set_timing(g, d, $urandom_range(1, 10));
			mark = ticks_queued;
			made = 0;
			while (ticks_queued - mark < 80 || made < 3) begin
				pick = $urandom_range(0, 19);
				if (pick < 15) begin
					push_random_char();
					made++;
				end else if (pick < 18) begin
					repeat ($urandom_range(1, 12))
						push_run(1'($urandom_range(0, 1)), $urandom_range(1, 2 * gap_lim + 4));
				end else begin
					if (glitch_lim != 0)
						push_run(1'b1, $urandom_range(1, glitch_lim));
					push_run(1'b0, gap_lim + 2 + $urandom_range(0, 4));
				end
				if ($urandom_range(0, 24) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
